@@ sv/rtas_pkg.sv @@
package rtas_pkg;

	// default table depth
	localparam int NUM_REGIONS_DEF = 8;

	// fixed field widths
	localparam int TAG_W  = 16;
	localparam int ADDR_W = 32;

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_READ   = 2'd2,
		ACT_WRITE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STS_OK           = 2'd0,
		STS_OUT_OF_RANGE = 2'd1,
		STS_FULL         = 2'd2,
		STS_NOT_FOUND    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FIN
	} fsm_t;

	// one table entry as held in a cell
	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [ADDR_W-1:0] size;
	} entry_t;

	// control broadcast to every cell
	typedef struct packed {
		logic shift;  // move one place toward the head
		logic drop;   // shift without wrap: head entry is discarded
		logic load;   // append into the cell at the current count
	} cell_ctl_t;

endpackage

@@ sv/rtas_req_if.sv @@
interface rtas_req_if;
	import rtas_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic [TAG_W-1:0]  region_tag;
	logic [ADDR_W-1:0] amount;
	logic [ADDR_W-1:0] address;

	modport source (output valid, output action, output region_tag, output amount,
		output address, input ready);
	modport sink (input valid, input action, input region_tag, input amount,
		input address, output ready);
endinterface

@@ sv/rtas_rsp_if.sv @@
interface rtas_rsp_if;
	import rtas_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [TAG_W-1:0]  segment_tag;
	logic [ADDR_W-1:0] segment_offset;
	logic [ADDR_W-1:0] segment_length;
	logic              is_write;
	logic              last;

	modport source (output valid, output status, output segment_tag,
		output segment_offset, output segment_length, output is_write, output last,
		input ready);
	modport sink (input valid, input status, input segment_tag,
		input segment_offset, input segment_length, input is_write, input last,
		output ready);
endinterface

@@ sv/rtas_cell.sv @@
module rtas_cell #(
	parameter int NUM_REGIONS = rtas_pkg::NUM_REGIONS_DEF,
	parameter int IDX         = 0
) (
	input  logic                                  clk,
	input  rtas_pkg::cell_ctl_t                   ctl,
	input  logic [$clog2(NUM_REGIONS+1)-1:0]      count,
	input  rtas_pkg::entry_t                      next,
	input  rtas_pkg::entry_t                      head,
	input  rtas_pkg::entry_t                      load_data,
	output rtas_pkg::entry_t                      ent
);
	import rtas_pkg::*;

	localparam int CW = $clog2(NUM_REGIONS+1);
	localparam logic [CW-1:0] POS  = CW'(IDX);
	localparam logic [CW-1:0] WRAP = CW'(IDX + 1);

	entry_t ent_q;

	// append, or move toward the head; the last live cell wraps the head around
	always_ff @(posedge clk) begin
		if (ctl.load && count == POS) begin
			ent_q <= load_data;
		end else if (ctl.shift) begin
			if (!ctl.drop && count == WRAP) begin
				ent_q <= head;
			end else begin
				ent_q <= next;
			end
		end
	end

	assign ent = ent_q;

endmodule

@@ sv/region_table_access_splitter_unit.sv @@
// Channel | Dir | Modport        | Word
// req     | in  | rtas_req_if    | action, region_tag, amount, address
// rsp     | out | rtas_rsp_if    | status, segment_tag, segment_offset, segment_length,
//         |     |                | is_write, last
//
// Add and zero-length split: answered straight into the output register on acceptance.
// Remove and split: the cell ring rotates once per live entry in S_WALK, then S_FIN
// ends the item; a step that produces a segment waits for the output register.
// Reset clears the entry count and control; table contents stay undefined.
// A stalled rsp freezes the ring only on a step that produces a segment.
module region_table_access_splitter_unit #(
	parameter int NUM_REGIONS = rtas_pkg::NUM_REGIONS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	rtas_req_if.sink  req,
	rtas_rsp_if.source rsp
);
	import rtas_pkg::*;

	localparam int CW = $clog2(NUM_REGIONS+1);
	localparam logic [CW-1:0] FULL_CNT = CW'(NUM_REGIONS);

	entry_t    ent [NUM_REGIONS];
	entry_t    head;
	entry_t    load_data;
	cell_ctl_t ctl;

	fsm_t              state_q, state_d;
	logic [CW-1:0]     count_q, len_q, step_q;
	logic [ADDR_W:0]   cur_q, base_q;
	logic [ADDR_W-1:0] rest_q;
	logic [TAG_W-1:0]  tag_q;
	logic              wr_q, is_rm_q, fin_q, found_q;

	logic              out_valid_q;
	status_t           o_status_q, o_status_d;
	logic [TAG_W-1:0]  o_tag_q, o_tag_d;
	logic [ADDR_W-1:0] o_off_q, o_off_d, o_len_q, o_len_d;
	logic              o_wr_q, o_wr_d, o_last_q, o_last_d;
	logic              out_load;

	logic              slot_free, accept, walking, step_go, hit, match, seg_last;
	logic              is_split;
	logic [ADDR_W+1:0] end_w, room;
	logic [ADDR_W-1:0] seg_len, seg_off;
	logic [ADDR_W:0]   base_nx;

	// ring of cells
	assign load_data = '{tag: req.region_tag, size: req.amount};
	assign head      = ent[0];

	for (genvar i = 0; i < NUM_REGIONS; i++) begin : g_cell
		rtas_cell #(.NUM_REGIONS(NUM_REGIONS), .IDX(i)) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.count     (count_q),
			.next      ((i == NUM_REGIONS - 1) ? ent[i] : ent[(i + 1) % NUM_REGIONS]),
			.head      (head),
			.load_data (load_data),
			.ent       (ent[i])
		);
	end

	// handshake
	assign slot_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && slot_free;
	assign accept    = req.valid && req.ready;
	assign is_split  = (req.action == ACT_READ) || (req.action == ACT_WRITE);

	// segment math against the head entry
	assign end_w    = {1'b0, base_q} + {2'b00, head.size};
	assign hit      = !is_rm_q && !fin_q && !cur_q[ADDR_W] && ({1'b0, cur_q} < end_w);
	assign room     = end_w - {1'b0, cur_q};
	assign seg_last = ({2'b00, rest_q} <= room);
	assign seg_len  = seg_last ? rest_q : room[ADDR_W-1:0];
	assign seg_off  = cur_q[ADDR_W-1:0] - base_q[ADDR_W-1:0];
	// bases at or past 4 GiB can never be hit, so saturate there
	assign base_nx  = (end_w[ADDR_W+1] || end_w[ADDR_W]) ? {1'b1, {ADDR_W{1'b0}}}
		: end_w[ADDR_W:0];
	assign match    = is_rm_q && !found_q && (head.tag == tag_q);

	assign walking  = (state_q == S_WALK) && (step_q != len_q);
	assign step_go  = walking && (!hit || slot_free);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && ((req.action == ACT_REMOVE) || (is_split && req.amount != '0)))
					state_d = S_WALK;
			end
			S_WALK: begin
				if (step_q == len_q)
					state_d = S_FIN;
			end
			S_FIN: begin
				if ((!is_rm_q && fin_q) || slot_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// cell control and output word
	always_comb begin
		ctl.shift  = step_go;
		ctl.drop   = step_go && match;
		ctl.load   = accept && (req.action == ACT_ADD) && (count_q != FULL_CNT);
		out_load   = 1'b0;
		o_status_d = STS_OK;
		o_tag_d    = '0;
		o_off_d    = '0;
		o_len_d    = '0;
		o_wr_d     = 1'b0;
		o_last_d   = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (accept && req.action == ACT_ADD) begin
					out_load   = 1'b1;
					o_status_d = (count_q == FULL_CNT) ? STS_FULL : STS_OK;
					o_tag_d    = req.region_tag;
				end else if (accept && is_split && req.amount == '0) begin
					out_load = 1'b1;
					o_wr_d   = (req.action == ACT_WRITE);
				end
			end
			S_WALK: begin
				if (step_go && hit) begin
					out_load = 1'b1;
					o_tag_d  = head.tag;
					o_off_d  = seg_off;
					o_len_d  = seg_len;
					o_wr_d   = wr_q;
					o_last_d = seg_last;
				end
			end
			S_FIN: begin
				if (slot_free && is_rm_q) begin
					out_load   = 1'b1;
					o_status_d = found_q ? STS_OK : STS_NOT_FOUND;
					o_tag_d    = tag_q;
				end else if (slot_free && !fin_q) begin
					out_load   = 1'b1;
					o_status_d = STS_OUT_OF_RANGE;
					o_wr_d     = wr_q;
				end
			end
			default: out_load = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load)
				count_q <= count_q + 1'b1;
			else if (ctl.drop)
				count_q <= count_q - 1'b1;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	// walk registers
	always_ff @(posedge clk) begin
		if (accept) begin
			len_q   <= count_q;
			step_q  <= '0;
			cur_q   <= {1'b0, req.address};
			base_q  <= '0;
			rest_q  <= req.amount;
			tag_q   <= req.region_tag;
			wr_q    <= (req.action == ACT_WRITE);
			is_rm_q <= (req.action == ACT_REMOVE);
			fin_q   <= 1'b0;
			found_q <= 1'b0;
		end else if (step_go) begin
			step_q <= step_q + 1'b1;
			if (match)
				found_q <= 1'b1;
			if (!is_rm_q && !fin_q)
				base_q <= base_nx;
			if (hit) begin
				rest_q <= rest_q - seg_len;
				cur_q  <= end_w[ADDR_W:0];
				fin_q  <= seg_last;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			o_status_q <= o_status_d;
			o_tag_q    <= o_tag_d;
			o_off_q    <= o_off_d;
			o_len_q    <= o_len_d;
			o_wr_q     <= o_wr_d;
			o_last_q   <= o_last_d;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = o_status_q;
	assign rsp.segment_tag    = o_tag_q;
	assign rsp.segment_offset = o_off_q;
	assign rsp.segment_length = o_len_q;
	assign rsp.is_write       = o_wr_q;
	assign rsp.last           = o_last_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count past table depth");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> slot_free)
		else $error("output word overwritten before taken");

	a_drop_on_remove: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.drop |-> (is_rm_q && state_q == S_WALK))
		else $error("entry dropped outside a remove walk");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (step_q <= len_q))
		else $error("walk ran past its length");

	a_one_drop: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.drop |=> !ctl.drop)
		else $error("more than one entry removed");

endmodule
